FILE: design/sparse_set_slot_allocator_unit_defines.svh
// ---------------------------------------------------------------------------
// Sparse set slot allocator: assertion macros
// Clocked, reset-qualified assertion wrappers shared by the checker.
// ---------------------------------------------------------------------------
`ifndef SPARSE_SET_SLOT_ALLOCATOR_UNIT_DEFINES_SVH
`define SPARSE_SET_SLOT_ALLOCATOR_UNIT_DEFINES_SVH

// Plain clocked property.
`define SSSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked on the cycle after a stalled output beat.
`define SSSA_ASSERT_STALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (m_axis_tvalid && !m_axis_tready) |=> prop) else $error(msg);

`endif

FILE: design/sssa_pkg.sv
// ---------------------------------------------------------------------------
// Sparse set slot allocator: package
// Sizes, field layout, command and status codes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sssa_pkg;

  localparam int ENTITY_SLOTS = 1024;
  localparam int DENSE_SLOTS  = 1024;
  localparam int VALUE_BITS   = 32;
  localparam int INDEX_BITS   = 20;

  localparam int IDX_W  = $clog2(ENTITY_SLOTS);
  localparam int SLOT_W = $clog2(DENSE_SLOTS);
  localparam int CNT_W  = $clog2(DENSE_SLOTS + 1);
  localparam int MAP_W  = SLOT_W + 1;

  localparam int CMD_W       = 2;
  localparam int ID_W        = 32;
  localparam int PAYLOAD_W   = 32;
  localparam int SLOT_OUT_W  = 10;
  localparam int COUNT_OUT_W = 11;
  localparam int STATUS_W    = 2;

  localparam int IN_BITS     = CMD_W + ID_W + PAYLOAD_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = 1 + SLOT_OUT_W + PAYLOAD_W + COUNT_OUT_W + STATUS_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_EMPLACE = 2'd0,
    CMD_REMOVE  = 2'd1,
    CMD_LOOKUP  = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_ABSENT = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_RANGE  = 2'd3
  } status_e;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [COUNT_OUT_W-1:0] slot_count;
    logic [PAYLOAD_W-1:0]   stored_value;
    logic [SLOT_OUT_W-1:0]  slot;
    logic                   found;
  } result_t;

endpackage

FILE: design/sssa_ram.sv
// ---------------------------------------------------------------------------
// Sparse set slot allocator: simple dual-port RAM
// One write port, one read port, registered read data held between reads.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sssa_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/sparse_set_slot_allocator_unit.sv
// ---------------------------------------------------------------------------
// Sparse set slot allocator
// Keyed slot store: reverse map, free list through forward links, values.
// ---------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel, one result per request leaves on
//   m_axis. tdata fields are listed beside the ports.
//   After reset the reverse map is swept to "not present", one entry per
//   cycle: s_axis_tready stays low until every entry is cleared.
//   One request is in flight at a time. A request is accepted in IDLE, the
//   reverse map read returns the next cycle, and emplace, remove,
//   out-of-range and absent-id lookup results are loaded into the output
//   register in S_MAP once it is free. A lookup of a present id adds a
//   value store read in S_VAL. The free-list head link is read in parallel
//   with the map, so a pop does not wait for a separate link read. A new
//   request is taken only after the last one leaves S_MAP or S_VAL, set by
//   the dependent map then value read. The output register lets a new
//   request be accepted while a result waits; if m_axis_tready is low the
//   next request holds its memory writes until the register frees.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sparse_set_slot_allocator_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [1:0] command, [33:2] entity_id, [65:34] payload, rest zero
  input  logic [sssa_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [0] found, [10:1] slot, [42:11] stored_value, [53:43] slot_count,
  // [55:54] status
  output logic [sssa_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MAP  = 2'd1;
  localparam logic [1:0] S_VAL  = 2'd2;
  localparam logic [1:0] S_CLR  = 2'd3;

  localparam int ID_LO  = sssa_pkg::CMD_W;
  localparam int PAY_LO = sssa_pkg::CMD_W + sssa_pkg::ID_W;

  logic [1:0] state_q, state_d;
  logic [sssa_pkg::IDX_W-1:0] clr_cnt_q;
  logic [sssa_pkg::CNT_W-1:0] free_head_q, free_head_d;
  logic [sssa_pkg::CNT_W-1:0] append_cnt_q, append_cnt_d;

  logic [sssa_pkg::CMD_W-1:0]      cmd_q;
  logic [sssa_pkg::IDX_W-1:0]      idx_q;
  logic [sssa_pkg::VALUE_BITS-1:0] data_q;
  logic                            oor_q;
  logic [sssa_pkg::SLOT_W-1:0]     slot_q, slot_d;

  logic                  m_valid_q;
  sssa_pkg::result_t     res_q, res_d;

  logic s_accept, out_free, to_val, load, commit;

  logic [sssa_pkg::INDEX_BITS-1:0] in_idx;
  logic                            in_oor;

  logic                        map_we, map_re;
  logic [sssa_pkg::IDX_W-1:0]  map_waddr, map_raddr;
  logic [sssa_pkg::MAP_W-1:0]  map_wdata, map_rdata;

  logic                        link_we;
  logic [sssa_pkg::SLOT_W-1:0] link_waddr;
  logic [sssa_pkg::CNT_W-1:0]  link_wdata, link_rdata;

  logic                           val_we, val_re;
  logic [sssa_pkg::SLOT_W-1:0]    val_waddr, val_raddr;
  logic [sssa_pkg::VALUE_BITS-1:0] val_wdata, val_rdata;

  logic                        present;
  logic [sssa_pkg::SLOT_W-1:0] mslot;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  assign in_idx = s_axis_tdata[ID_LO +: sssa_pkg::INDEX_BITS];
  assign in_oor = {1'b0, in_idx} >= (sssa_pkg::INDEX_BITS + 1)'(sssa_pkg::ENTITY_SLOTS);

  assign map_re    = s_accept;
  assign map_raddr = in_idx[sssa_pkg::IDX_W-1:0];

  assign present = map_rdata[sssa_pkg::SLOT_W];
  assign mslot   = map_rdata[sssa_pkg::SLOT_W-1:0];

  sssa_ram #(
    .DEPTH (sssa_pkg::ENTITY_SLOTS),
    .WIDTH (sssa_pkg::MAP_W)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (map_re),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  // Head link is prefetched with the map read.
  sssa_ram #(
    .DEPTH (sssa_pkg::DENSE_SLOTS),
    .WIDTH (sssa_pkg::CNT_W)
  ) u_link (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (s_accept),
    .raddr_i (free_head_q[sssa_pkg::SLOT_W-1:0]),
    .rdata_o (link_rdata)
  );

  sssa_ram #(
    .DEPTH (sssa_pkg::DENSE_SLOTS),
    .WIDTH (sssa_pkg::VALUE_BITS)
  ) u_val (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_wdata),
    .re_i    (val_re),
    .raddr_i (val_raddr),
    .rdata_o (val_rdata)
  );

  always_comb begin
    logic                        w_map, w_val, w_link;
    logic [sssa_pkg::SLOT_W-1:0] nslot;

    w_map        = 1'b0;
    w_val        = 1'b0;
    w_link       = 1'b0;
    nslot        = mslot;
    to_val       = 1'b0;
    load         = 1'b0;
    state_d      = state_q;
    slot_d       = slot_q;
    free_head_d  = free_head_q;
    append_cnt_d = append_cnt_q;
    map_wdata    = '0;
    res_d        = '0;
    val_re       = 1'b0;
    val_raddr    = mslot;

    case (state_q)
      S_CLR: begin
        if (clr_cnt_q == sssa_pkg::IDX_W'(sssa_pkg::ENTITY_SLOTS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_accept) begin
          state_d = S_MAP;
        end
      end
      S_MAP: begin
        if (oor_q) begin
          res_d.status = sssa_pkg::STAT_RANGE;
        end else begin
          case (cmd_q)
            sssa_pkg::CMD_EMPLACE: begin
              if (present) begin
                w_val              = 1'b1;
                res_d.found        = 1'b1;
                res_d.slot         = sssa_pkg::SLOT_OUT_W'(mslot);
                res_d.stored_value = sssa_pkg::PAYLOAD_W'(data_q);
              end else if (free_head_q != sssa_pkg::CNT_W'(sssa_pkg::DENSE_SLOTS)) begin
                nslot       = free_head_q[sssa_pkg::SLOT_W-1:0];
                free_head_d = (link_rdata > sssa_pkg::CNT_W'(sssa_pkg::DENSE_SLOTS)) ?
                              sssa_pkg::CNT_W'(sssa_pkg::DENSE_SLOTS) : link_rdata;
                w_val       = 1'b1;
                w_map       = 1'b1;
              end else if (append_cnt_q != sssa_pkg::CNT_W'(sssa_pkg::DENSE_SLOTS)) begin
                nslot        = append_cnt_q[sssa_pkg::SLOT_W-1:0];
                append_cnt_d = append_cnt_q + 1'b1;
                w_val        = 1'b1;
                w_map        = 1'b1;
              end else begin
                res_d.status = sssa_pkg::STAT_FULL;
              end
              if (!present && w_map) begin
                map_wdata          = {1'b1, nslot};
                res_d.slot         = sssa_pkg::SLOT_OUT_W'(nslot);
                res_d.stored_value = sssa_pkg::PAYLOAD_W'(data_q);
              end
            end
            sssa_pkg::CMD_REMOVE: begin
              if (present) begin
                w_link      = 1'b1;
                w_map       = 1'b1;
                map_wdata   = {1'b0, mslot};
                free_head_d = sssa_pkg::CNT_W'(mslot);
                res_d.found = 1'b1;
                res_d.slot  = sssa_pkg::SLOT_OUT_W'(mslot);
              end else begin
                res_d.status = sssa_pkg::STAT_ABSENT;
              end
            end
            default: begin
              if (present) begin
                to_val = 1'b1;
                val_re = 1'b1;
                slot_d = mslot;
              end else begin
                res_d.status = sssa_pkg::STAT_ABSENT;
              end
            end
          endcase
        end
        res_d.slot_count = sssa_pkg::COUNT_OUT_W'(append_cnt_d);
        if (to_val) begin
          state_d = S_VAL;
        end else if (out_free) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_VAL: begin
        res_d.found        = 1'b1;
        res_d.slot         = sssa_pkg::SLOT_OUT_W'(slot_q);
        res_d.stored_value = sssa_pkg::PAYLOAD_W'(val_rdata);
        res_d.slot_count   = sssa_pkg::COUNT_OUT_W'(append_cnt_q);
        if (out_free) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    commit = (state_q == S_MAP) && load;

    map_we     = (state_q == S_CLR) || (commit && w_map);
    map_waddr  = (state_q == S_CLR) ? clr_cnt_q : idx_q;
    val_we     = commit && w_val;
    val_waddr  = nslot;
    val_wdata  = data_q;
    link_we    = commit && w_link;
    link_waddr = mslot;
    link_wdata = free_head_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLR;
      clr_cnt_q    <= '0;
      free_head_q  <= sssa_pkg::CNT_W'(sssa_pkg::DENSE_SLOTS);
      append_cnt_q <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (commit) begin
        free_head_q  <= free_head_d;
        append_cnt_q <= append_cnt_d;
      end
      if (load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      cmd_q  <= s_axis_tdata[sssa_pkg::CMD_W-1:0];
      idx_q  <= in_idx[sssa_pkg::IDX_W-1:0];
      data_q <= s_axis_tdata[PAY_LO +: sssa_pkg::VALUE_BITS];
      oor_q  <= in_oor;
    end
    slot_q <= slot_d;
    if (load) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = sssa_pkg::OUT_TDATA_W'(res_q);

endmodule

FILE: design/sssa_checker.sv
// ---------------------------------------------------------------------------
// Sparse set slot allocator: port checker
// Output channel rules and result consistency, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sparse_set_slot_allocator_unit_defines.svh"

module sssa_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [sssa_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [sssa_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  sssa_pkg::result_t res;
  logic              in_beat;

  assign res     = sssa_pkg::result_t'(m_axis_tdata[sssa_pkg::OUT_BITS-1:0]);
  assign in_beat = s_axis_tvalid && s_axis_tready && (s_axis_tdata != '1);

  `SSSA_ASSERT_STALL(a_valid_hold, m_axis_tvalid, "output beat dropped while stalled")
  `SSSA_ASSERT_STALL(a_data_hold, $stable(m_axis_tdata), "stalled output beat changed")
  `SSSA_ASSERT(a_count_max, m_axis_tvalid |-> (res.slot_count <= sssa_pkg::COUNT_OUT_W'(sssa_pkg::DENSE_SLOTS)), "slot count above capacity")
  `SSSA_ASSERT(a_fail_empty, (m_axis_tvalid && (res.status == sssa_pkg::STAT_RANGE || res.status == sssa_pkg::STAT_FULL || res.status == sssa_pkg::STAT_ABSENT)) |-> (!res.found && res.slot == '0 && res.stored_value == '0), "failed request carries data")
  `SSSA_ASSERT(a_one_busy, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready || !in_beat, "second request taken back to back")

endmodule

bind sparse_set_slot_allocator_unit sssa_checker u_sssa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
